FILE: sv/ftv_pkg.sv
`timescale 1ns / 1ps
package ftv_pkg;

	// Tag accumulator geometry
	localparam int TAG_DIGITS = 5;
	localparam int TAG_W      = 17;
	localparam int CNT_W      = 4;
	localparam int VPOS_W     = 3;
	localparam int VERSION_LEN = 7;

	// Stream bytes and tags of interest
	localparam logic [7:0] SEP_BYTE   = 8'h01;
	localparam logic [7:0] EQ_BYTE    = 8'h3D;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;
	localparam logic [TAG_W-1:0] TAG_BEGIN    = TAG_W'(8);
	localparam logic [TAG_W-1:0] TAG_MSGTYPE  = TAG_W'(35);
	localparam logic [TAG_W-1:0] TAG_CHECKSUM = TAG_W'(10);

	// Result kinds
	localparam logic [1:0] KIND_VALUE = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_GOOD  = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_BAD_TAG  = 3'd1;
	localparam logic [2:0] ERR_NO_VALUE = 3'd2;
	localparam logic [2:0] ERR_VERSION  = 3'd3;
	localparam logic [2:0] ERR_MSGTYPE  = 3'd4;

	typedef enum logic [1:0] {
		MODE_TAG   = 2'd0,
		MODE_VALUE = 2'd1,
		MODE_SKIP  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [TAG_W-1:0] field_tag;
		logic [7:0]       value_byte;
		logic [2:0]       error_code;
	} result_t;

	// Expected BeginString text "FIX.4.2"
	function automatic logic [7:0] version_char(input logic [VPOS_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h46; // F
			3'd1: c = 8'h49; // I
			3'd2: c = 8'h58; // X
			3'd3: c = 8'h2E; // .
			3'd4: c = 8'h34; // 4
			3'd5: c = 8'h2E; // .
			3'd6: c = 8'h32; // 2
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/ftv_byte_if.sv
`timescale 1ns / 1ps
interface ftv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: sv/ftv_result_if.sv
`timescale 1ns / 1ps
interface ftv_result_if;
	import ftv_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       kind;
	logic [TAG_W-1:0] field_tag;
	logic [7:0]       value_byte;
	logic [2:0]       error_code;

	modport source (output valid, output kind, output field_tag, output value_byte,
		output error_code, input ready);
	modport sink   (input valid, input kind, input field_tag, input value_byte,
		input error_code, output ready);
endinterface

FILE: sv/ftv_parse.sv
`timescale 1ns / 1ps
module ftv_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	output logic              res_valid,
	output ftv_pkg::result_t  res
);
	import ftv_pkg::*;

	mode_t             mode_q, mode_d;
	logic [TAG_W-1:0]  tag_q, tag_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [VPOS_W-1:0] vpos_q, vpos_d;
	logic              vmatch_q, vmatch_d;
	logic              vgood_q, vgood_d;
	logic              mt_seen_q, mt_seen_d;

	logic              is_digit;
	logic              is_sep;
	logic [TAG_W+3:0]  tag_x10;

	assign is_digit = (data_byte >= DIGIT_LO) && (data_byte <= DIGIT_HI);
	assign is_sep   = (data_byte == SEP_BYTE);
	// tag*10 + digit; digits 0x30..0x39 carry their value in the low nibble
	assign tag_x10  = {1'b0, tag_q, 3'b000} + {3'b000, tag_q, 1'b0}
		+ {(TAG_W)'(0), data_byte[3:0]};

	always_comb begin
		mode_d    = mode_q;
		tag_d     = tag_q;
		cnt_d     = cnt_q;
		vpos_d    = vpos_q;
		vmatch_d  = vmatch_q;
		vgood_d   = vgood_q;
		mt_seen_d = mt_seen_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_VALUE, field_tag: tag_q, value_byte: 8'h00,
			error_code: ERR_NONE};

		case (mode_q)
			MODE_SKIP: begin
				if (is_sep) begin
					mode_d = MODE_TAG;
					tag_d  = '0;
					cnt_d  = '0;
				end
			end
			MODE_VALUE: begin
				if (!is_sep) begin
					if (tag_q == TAG_BEGIN) begin
						if (vpos_q < VPOS_W'(VERSION_LEN)) begin
							if (version_char(vpos_q) != data_byte)
								vmatch_d = 1'b0;
							vpos_d = vpos_q + VPOS_W'(1);
						end else begin
							vmatch_d = 1'b0;
						end
					end
					res_valid      = 1'b1;
					res.value_byte = data_byte;
				end else begin
					mode_d = MODE_TAG;
					tag_d  = '0;
					cnt_d  = '0;
					if (tag_q == TAG_BEGIN)
						vgood_d = vmatch_q && (vpos_q == VPOS_W'(VERSION_LEN));
					res_valid = 1'b1;
					if (tag_q == TAG_CHECKSUM) begin
						vgood_d   = 1'b0;
						mt_seen_d = 1'b0;
						if (!vgood_q) begin
							res.kind       = KIND_ERROR;
							res.error_code = ERR_VERSION;
						end else if (!mt_seen_q) begin
							res.kind       = KIND_ERROR;
							res.error_code = ERR_MSGTYPE;
						end else begin
							res.kind = KIND_GOOD;
						end
					end else begin
						res.kind = KIND_END;
					end
				end
			end
			default: begin
				// tag mode (unused code behaves the same)
				if (is_digit) begin
					if (cnt_q >= CNT_W'(TAG_DIGITS)) begin
						mode_d         = MODE_SKIP;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_TAG;
					end else begin
						tag_d = tag_x10[TAG_W-1:0];
						cnt_d = cnt_q + CNT_W'(1);
					end
				end else if (data_byte == EQ_BYTE) begin
					if (cnt_q == '0) begin
						mode_d         = MODE_SKIP;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_BAD_TAG;
					end else begin
						mode_d = MODE_VALUE;
						if (tag_q == TAG_BEGIN) begin
							vpos_d   = '0;
							vmatch_d = 1'b1;
						end
						if (tag_q == TAG_MSGTYPE)
							mt_seen_d = 1'b1;
					end
				end else if (is_sep) begin
					mode_d         = MODE_TAG;
					tag_d          = '0;
					cnt_d          = '0;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_NO_VALUE;
				end else begin
					mode_d         = MODE_SKIP;
					res_valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_BAD_TAG;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TAG;
			tag_q     <= '0;
			cnt_q     <= '0;
			vpos_q    <= '0;
			vmatch_q  <= 1'b1;
			vgood_q   <= 1'b0;
			mt_seen_q <= 1'b0;
		end else if (step) begin
			mode_q    <= mode_d;
			tag_q     <= tag_d;
			cnt_q     <= cnt_d;
			vpos_q    <= vpos_d;
			vmatch_q  <= vmatch_d;
			vgood_q   <= vgood_d;
			mt_seen_q <= mt_seen_d;
		end
	end

endmodule

FILE: sv/ftv_out_stage.sv
`timescale 1ns / 1ps
module ftv_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             res_valid,
	input  ftv_pkg::result_t res,
	output logic             take,
	ftv_result_if.source     result_out
);
	import ftv_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Register can load when empty or when its word leaves this cycle
	assign take = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= step && res_valid;
	end

	always_ff @(posedge clk) begin
		if (take && step && res_valid)
			data_q <= res;
	end

	assign result_out.valid      = valid_q;
	assign result_out.kind       = data_q.kind;
	assign result_out.field_tag  = data_q.field_tag;
	assign result_out.value_byte = data_q.value_byte;
	assign result_out.error_code = data_q.error_code;

endmodule

FILE: sv/fix_tag_value_stream_parser_top.sv
`timescale 1ns / 1ps
// FIX tag=value stream parser.
// byte_in carries one stream byte per word (data_byte). result_out carries at
// most one word per byte: kind (value byte, field end, message good, error),
// field_tag, value_byte and error_code.
// Structure: input register -> parse logic with the parser state -> result
// register. With no stall one byte is taken every cycle. A byte accepted into
// the input register is parsed there, and its word is loaded into the result
// register when the parser steps on it. Bytes that cause no result (tag
// digits, the '=' closing a good tag, skipped bytes) just advance the parser
// state and leave the result register empty for that cycle.
// The rate is set by the single parse stage: all state updates for one byte
// are made in one parser step.
// When result_out stalls, the result register holds its word and the parser
// does not advance, since it only steps when the result register can load;
// the stall reaches byte_in.ready in the same cycle once the input register
// is full.
// Reset (arst_n low) empties both registers and puts the parser in tag mode
// with a cleared tag, no BeginString verdict and no MsgType seen.
module fix_tag_value_stream_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	ftv_byte_if.sink     byte_in,
	ftv_result_if.source result_out
);
	import ftv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	logic       step;
	logic       res_valid;
	result_t    res;

	// parser consumes the held byte whenever the result register can load
	assign step          = valid_s1 && take;
	assign byte_in.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_in.ready)
			valid_s1 <= byte_in.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid)
			byte_s1 <= byte_in.data_byte;
	end

	ftv_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ftv_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.res_valid  (res_valid),
		.res        (res),
		.take       (take),
		.result_out (result_out)
	);

endmodule

FILE: tb/fix_tag_value_stream_parser_top_test.sv
`timescale 1ns / 1ps
module fix_tag_value_stream_parser_top_test;
	import ftv_pkg::*;

	localparam int LATENCY       = 1;
	localparam int SETTLE_CYCLES = LATENCY + 6;
	localparam int STALL_LIMIT   = 2000;   // cycles with no word moving on either side
	localparam int RANDOM_BYTES  = 1850;
	localparam int IDLE_PCT      = 37;

	// BeginString text the parser checks for
	localparam logic [7:0] BEGIN_TEXT [0:VERSION_LEN-1] = '{"F", "I", "X", ".", "4", ".", "2"};

	logic clk;
	logic arst_n;

	ftv_byte_if   byte_ch();
	ftv_result_if res_ch();

	fix_tag_value_stream_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (res_ch)
	);

	// Parser model state, advanced once per accepted byte
	mode_t            parse_state;
	logic [TAG_W-1:0] tag_value;
	logic [CNT_W-1:0] tag_digits;
	logic [VPOS_W-1:0] begin_pos;    // next index into the BeginString text, sticks at 7
	logic             begin_match;  // BeginString value matches so far
	logic             begin_ok;     // last complete BeginString was exactly the text
	logic             msgtype_flag; // MsgType entered since last checksum field

	result_t    results_due[$];     // predicted words not yet seen on result_out
	logic [7:0] frame[$];           // bytes of the next chunk of stream to send

	int errors;
	int quiet_cycles;
	int sent_bytes;
	bit steady;                     // both sides stop idling while set

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Work out the word (if any) that one stream byte produces.
	function automatic void advance_parser(input logic [7:0] b);
		logic [TAG_W-1:0] tag;
		result_t word;
		bit emits;
		int grown;
		tag   = tag_value;
		word  = '{KIND_VALUE, tag, 8'h00, ERR_NONE};
		emits = 1'b1;
		case (parse_state)
			MODE_SKIP: begin
				// dropped bytes; SOH resumes tag parsing
				emits = 1'b0;
				if (b == SEP_BYTE) begin
					parse_state = MODE_TAG;
					tag_value   = '0;
					tag_digits  = '0;
				end
			end
			MODE_VALUE: begin
				if (b != SEP_BYTE) begin
					if (tag == TAG_BEGIN) begin
						if (begin_pos < VERSION_LEN) begin
							if (BEGIN_TEXT[begin_pos] != b)
								begin_match = 1'b0;
							begin_pos++;
						end else begin
							begin_match = 1'b0;
						end
					end
					word.value_byte = b;
				end else begin
					parse_state = MODE_TAG;
					tag_value   = '0;
					tag_digits  = '0;
					if (tag == TAG_BEGIN)
						begin_ok = begin_match && begin_pos == VERSION_LEN;
					if (tag == TAG_CHECKSUM) begin
						// verdict replaces the field end; version outranks msgtype
						word.kind = KIND_ERROR;
						if (!begin_ok)
							word.error_code = ERR_VERSION;
						else if (!msgtype_flag)
							word.error_code = ERR_MSGTYPE;
						else
							word.kind = KIND_GOOD;
						begin_ok     = 1'b0;
						msgtype_flag = 1'b0;
					end else begin
						word.kind = KIND_END;
					end
				end
			end
			default: begin
				// tag mode (also covers the unused mode code)
				if (b >= DIGIT_LO && b <= DIGIT_HI) begin
					if (tag_digits >= TAG_DIGITS) begin
						// overlong: report the tag as it stood
						parse_state     = MODE_SKIP;
						word.kind       = KIND_ERROR;
						word.error_code = ERR_BAD_TAG;
					end else begin
						grown      = int'(tag_value) * 10 + int'(b - DIGIT_LO);
						tag_value  = grown[TAG_W-1:0];
						tag_digits++;
						emits      = 1'b0;
					end
				end else if (b == EQ_BYTE) begin
					if (tag_digits == 0) begin
						parse_state     = MODE_SKIP;
						word.kind       = KIND_ERROR;
						word.error_code = ERR_BAD_TAG;
					end else begin
						parse_state = MODE_VALUE;
						emits       = 1'b0;
						if (tag == TAG_BEGIN) begin
							begin_pos   = '0;
							begin_match = 1'b1;
						end
						if (tag == TAG_MSGTYPE)
							msgtype_flag = 1'b1;
					end
				end else if (b == SEP_BYTE) begin
					// SOH before '=', even on an empty tag
					parse_state     = MODE_TAG;
					tag_value       = '0;
					tag_digits      = '0;
					word.kind       = KIND_ERROR;
					word.error_code = ERR_NO_VALUE;
				end else begin
					parse_state     = MODE_SKIP;
					word.kind       = KIND_ERROR;
					word.error_code = ERR_BAD_TAG;
				end
			end
		endcase
		if (emits)
			results_due.push_back(word);
	endfunction

	// Result side: ready toggles at random except in the steady stretch.
	always @(negedge clk) begin
		res_ch.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
	end

	// Check results, predict from accepted bytes, and watch for a hang.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		seen = '{res_ch.kind, res_ch.field_tag, res_ch.value_byte, res_ch.error_code};
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, got kind=%0d tag=%0d byte=%02h err=%0d",
					$time, seen.kind, seen.field_tag, seen.value_byte, seen.error_code);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (seen.kind !== want.kind || seen.field_tag !== want.field_tag ||
						seen.value_byte !== want.value_byte || seen.error_code !== want.error_code) begin
					$display("%0t: mismatch, expected kind=%0d tag=%0d byte=%02h err=%0d",
						$time, want.kind, want.field_tag, want.value_byte, want.error_code);
					$display("%0t:           actual   kind=%0d tag=%0d byte=%02h err=%0d",
						$time, seen.kind, seen.field_tag, seen.value_byte, seen.error_code);
					errors++;
				end
			end
		end
		// a byte accepted now cannot have its word out before the next edge
		if (arst_n && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
			advance_parser(byte_ch.data_byte);

		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no word moved for %0d cycles, %0d words outstanding",
				$time, STALL_LIMIT, results_due.size());
			$display("FAIL fix_tag_value_stream_parser_top");
			$finish;
		end
	end

	// One stream byte: random idle cycles, then hold valid until taken.
	// Valid stays high across back-to-back words.
	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		sent_bytes++;
	endtask

	// '|' in frame text stands for SOH.
	function automatic void add_text(input string s);
		foreach (s[i])
			frame.push_back(s[i] == "|" ? SEP_BYTE : s[i]);
	endfunction

	// Value bytes: anything but 0x00 and SOH, '=' now and then.
	function automatic void add_value(input int max_len);
		repeat ($urandom_range(0, max_len))
			frame.push_back($urandom_range(0, 7) == 0 ? EQ_BYTE : 8'($urandom_range(2, 255)));
	endfunction

	function automatic string tag_text();
		int unsigned known [3] = '{8, 35, 10};
		case ($urandom_range(0, 7))
			0:       return $sformatf("%06d", $urandom_range(0, 999999)); // one digit too many
			1:       return $sformatf("%03d", known[$urandom_range(0, 2)]); // leading zeros
			2:       return $sformatf("%0d", $urandom_range(0, 9));
			default: return $sformatf("%0d", $urandom_range(0, 99999));
		endcase
	endfunction

	// Mostly well formed: BeginString, MsgType, body fields, checksum.
	function automatic void build_message();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 1) begin
			add_text("8=");
			add_value(9);
			add_text("|");
		end else if (pick == 2) begin
			if ($urandom_range(0, 1) != 0)
				add_text("8=FIX.4.|");
			else
				add_text("8=FIX.4.22|");
		end else if (pick != 0) begin
			add_text("8=FIX.4.2|");
		end
		if ($urandom_range(0, 99) < 85) begin
			add_text("35=");
			add_value(2);
			add_text("|");
		end
		repeat ($urandom_range(0, 4)) begin
			add_text({tag_text(), "="});
			add_value(6);
			add_text("|");
		end
		add_text($sformatf("10=%03d|", $urandom_range(0, 255)));
	endfunction

	task automatic send_frame();
		foreach (frame[i])
			push_byte(frame[i]);
		frame.delete();
	endtask

	// Drop valid and hold off until every predicted word has come out.
	task automatic wait_drained();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	// Good message; MsgType with an empty value still counts. The body
	// field carries both byte extremes and an embedded '='.
	task automatic test_good_message();
		add_text("8=FIX.4.2|35=|1=");
		frame.push_back(8'h00);
		frame.push_back(8'hFF);
		add_text("=|10=|");
		send_frame();
	endtask

	// Empty tag, SOH before '=' (with and without digits), overlong tag,
	// non-digit in tag; each skip ends at the next SOH.
	task automatic test_tag_errors();
		add_text("=|7||999999|7x|");
		send_frame();
	endtask

	// Empty BeginString is a bad version; a leading-zero tag 8 with the
	// right text but no MsgType gives the msgtype error.
	task automatic test_message_verdicts();
		add_text("8=|10=|008=FIX.4.2|10=|");
		send_frame();
	endtask

	// Random stream: 70% clean messages, 15% with one byte corrupted,
	// 15% noise biased toward digits, '=' and SOH.
	task automatic test_random_stream();
		int start;
		int pick;
		bit paused;
		start  = sent_bytes;
		paused = 1'b0;
		while (sent_bytes < start + RANDOM_BYTES) begin
			steady = (sent_bytes - start) inside {[600:899]};
			if (!paused && sent_bytes - start > 1300) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				build_message();
				if (pick >= 70)
					frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
			end else begin
				repeat ($urandom_range(1, 12)) begin
					case ($urandom_range(0, 7))
						0, 1:    frame.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
						2:       frame.push_back(EQ_BYTE);
						3:       frame.push_back(SEP_BYTE);
						default: frame.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
			send_frame();
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'h00;
		res_ch.ready      = 1'b0;
		errors            = 0;
		quiet_cycles      = 0;
		sent_bytes        = 0;
		steady            = 1'b0;

		// model comes out of reset in tag mode with no verdict flags
		parse_state  = MODE_TAG;
		tag_value    = '0;
		tag_digits   = '0;
		begin_pos    = '0;
		begin_match  = 1'b1;
		begin_ok     = 1'b0;
		msgtype_flag = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_good_message();
		test_tag_errors();
		test_message_verdicts();
		test_random_stream();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: %0d expected words never came out", $time, results_due.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS fix_tag_value_stream_parser_top");
		else
			$display("FAIL fix_tag_value_stream_parser_top");
		$finish;
	end

endmodule
